>>> sv/hfa_pkg.sv
// Package for the hole fit allocator: command, policy and register codes,
// default parameter values and the scan control bundle. No dependencies.
`default_nettype none

package hfa_pkg;

  // Default sizing of the hole table
  localparam int MAX_HOLES_DEF = 16;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed field widths of the stream ports
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int VALUE_W = 16;
  localparam int FRAG_W  = 20;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 5;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 48;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] REG_FIT_MODE   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLE_COUNT = 1'd1;
  localparam logic [MODE_W-1:0]     FIT_MODE_RST   = 2'd0;
  localparam logic [COUNT_W-1:0]    HOLE_COUNT_RST = 5'd16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQ   = 2'd2;

  // Placement policies; the unused code behaves as first fit
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Control bundle handed from cell to cell during a scan
  typedef struct packed {
    logic live;
    logic found;
  } scan_ctl_t;

endpackage

`default_nettype wire

>>> sv/hfa_cell.sv
// One cell of the hole chain: holds one hole size and its used mark, and
// updates the passing scan candidate. Depends on hfa_pkg.
`default_nettype none

module hfa_cell #(
  parameter int INDEX     = 0,
  parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF,
  parameter int IDX_W     = 4,
  parameter int TOT_W     = 26
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            ld_en,
  input  wire [hfa_pkg::SLOT_W-1:0]      ld_slot,
  input  wire [SIZE_BITS-1:0]            ld_size,
  input  wire                            clr_marks,
  input  wire                            mark_en,
  input  wire [IDX_W-1:0]                mark_idx,
  input  wire [hfa_pkg::MODE_W-1:0]      fit_mode,
  input  wire [hfa_pkg::COUNT_W-1:0]     hole_count,
  input  wire [SIZE_BITS-1:0]            req_size,
  input  hfa_pkg::scan_ctl_t             ctl_in,
  input  wire [IDX_W-1:0]                pick_in,
  input  wire [SIZE_BITS-1:0]            best_in,
  input  wire [TOT_W-1:0]                sum_in,
  output hfa_pkg::scan_ctl_t             ctl_out,
  output logic [IDX_W-1:0]               pick_out,
  output logic [SIZE_BITS-1:0]           best_out,
  output logic [TOT_W-1:0]               sum_out
);

  logic [SIZE_BITS-1:0] hole_size;
  logic                 hole_used;
  logic                 slot_hit;
  logic                 in_range;
  logic                 cand;
  logic                 take;
  hfa_pkg::scan_ctl_t   ctl_next;
  logic [IDX_W-1:0]     pick_next;
  logic [SIZE_BITS-1:0] best_next;
  logic [TOT_W-1:0]     sum_next;

  assign slot_hit = (9'(ld_slot) == 9'(INDEX));
  assign in_range = (9'(hole_count) > 9'(INDEX));
  assign cand     = in_range && !hole_used;

  // Hold the hole size; reload on a matching load
  always_ff @(posedge clk) begin
    if (rst) begin
      hole_size <= '0;
    end else if (ld_en && slot_hit) begin
      hole_size <= ld_size;
    end
  end

  // Set the used mark on a grant, drop it on a clear
  always_ff @(posedge clk) begin
    if (rst || clr_marks) begin
      hole_used <= 1'b0;
    end else if (mark_en && (mark_idx == IDX_W'(INDEX))) begin
      hole_used <= 1'b1;
    end
  end

  // Decide whether this hole replaces the running candidate
  always_comb begin
    if (fit_mode == hfa_pkg::FIT_WORST) begin
      take = cand && (!ctl_in.found || (hole_size > best_in));
    end else begin
      take = cand && (hole_size >= req_size) &&
             (!ctl_in.found || ((fit_mode == hfa_pkg::FIT_BEST) && (hole_size < best_in)));
    end
    ctl_next.live  = ctl_in.live;
    ctl_next.found = ctl_in.found || take;
    pick_next      = take ? IDX_W'(INDEX) : pick_in;
    best_next      = take ? hole_size : best_in;
    sum_next       = in_range ? (sum_in + TOT_W'(hole_size)) : sum_in;
  end

  // Advance the candidate to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    pick_out <= pick_next;
    best_out <= best_next;
    sum_out  <= sum_next;
  end

endmodule

`default_nettype wire

>>> sv/hole_fit_allocator_top.sv
// Top level of the hole fit allocator: stream ports, configuration
// registers, request sequencing and the chain of hfa_cell. Depends on hfa_pkg.
//
// The block keeps MAX_HOLES hole sizes and used marks in a chain of cells.
// Load (command 0) and clear (command 1) take effect at the edge they are
// accepted and give no result; command 3 is dropped. A request (command 2)
// walks a candidate through the chain one cell per cycle; its outcome is
// registered as it leaves the chain and then moves to the output register,
// and the next request can be accepted in the cycle that the result is
// presented. The input is not ready while a request is in the chain,
// nor while its finished outcome waits for the output register to free up;
// a presented result may still wait in the output register while new
// requests are taken. Sizes are taken in their low SIZE_BITS bits. No
// clearing pass follows reset.
`default_nettype none

module hole_fit_allocator_top #(
  parameter int MAX_HOLES = hfa_pkg::MAX_HOLES_DEF,
  parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // Request stream
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [hfa_pkg::IN_W-1:0]          s_tdata,  // slot[3:0], size_value[19:4]
  input  wire [hfa_pkg::CMD_W-1:0]         s_tuser,  // command[1:0]
  // Result stream
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [hfa_pkg::OUT_W-1:0]        m_tdata,  // granted[0], granted_slot[4:1],
                                                     // leftover[20:5],
                                                     // total_fragmentation[40:21]
  // Configuration
  input  wire                              cfg_we,
  input  wire [hfa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire [hfa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_HOLES);
  localparam int TOT_W = SIZE_BITS + $clog2(MAX_HOLES) + 6;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                    state;
  logic [hfa_pkg::MODE_W-1:0]    fit_mode;
  logic [hfa_pkg::COUNT_W-1:0]   hole_count;
  logic [SIZE_BITS-1:0]          req_size;
  logic                          start;
  logic [TOT_W-1:0]              hole_total;
  logic [TOT_W-1:0]              granted_total;
  logic                          res_granted;
  logic [IDX_W-1:0]              res_slot;
  logic [SIZE_BITS-1:0]          res_left;

  logic                          accept;
  logic [hfa_pkg::SLOT_W-1:0]    in_slot;
  logic [SIZE_BITS+hfa_pkg::VALUE_W-1:0] size_wide;
  logic [SIZE_BITS-1:0]          in_size;
  logic                          ld_en;
  logic                          clr_marks;
  logic                          final_step;
  logic                          final_found;
  logic                          mark_en;
  logic [TOT_W-1:0]              frag;
  logic [TOT_W+hfa_pkg::FRAG_W-1:0]       frag_wide;
  logic [IDX_W+hfa_pkg::SLOT_W-1:0]       slot_wide;
  logic [SIZE_BITS+hfa_pkg::VALUE_W-1:0]  left_wide;

  hfa_pkg::scan_ctl_t            ctl_w  [0:MAX_HOLES];
  logic [IDX_W-1:0]              pick_w [0:MAX_HOLES];
  logic [SIZE_BITS-1:0]          best_w [0:MAX_HOLES];
  logic [TOT_W-1:0]              sum_w  [0:MAX_HOLES];

  // Decode the incoming request
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_slot   = s_tdata[3:0];
  assign size_wide = {{SIZE_BITS{1'b0}}, s_tdata[19:4]};
  assign in_size   = size_wide[SIZE_BITS-1:0];
  assign ld_en     = accept && (s_tuser == hfa_pkg::CMD_LOAD);
  assign clr_marks = accept && (s_tuser == hfa_pkg::CMD_CLEAR);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= hfa_pkg::FIT_MODE_RST;
      hole_count <= hfa_pkg::HOLE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hfa_pkg::REG_FIT_MODE:   fit_mode   <= cfg_wdata[hfa_pkg::MODE_W-1:0];
        hfa_pkg::REG_HOLE_COUNT: hole_count <= cfg_wdata[hfa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Feed the head of the chain
  assign ctl_w[0].live  = start;
  assign ctl_w[0].found = 1'b0;
  assign pick_w[0]      = '0;
  assign best_w[0]      = '0;
  assign sum_w[0]       = '0;

  // Resolve the candidate leaving the chain
  assign final_step  = (state == S_SCAN) && ctl_w[MAX_HOLES].live;
  assign final_found = ctl_w[MAX_HOLES].found &&
                       ((fit_mode != hfa_pkg::FIT_WORST) || (best_w[MAX_HOLES] >= req_size));
  assign mark_en     = final_step && final_found;

  genvar g;
  generate
    for (g = 0; g < MAX_HOLES; g++) begin : g_cell
      hfa_cell #(
        .INDEX     (g),
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W),
        .TOT_W     (TOT_W)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ld_en      (ld_en),
        .ld_slot    (in_slot),
        .ld_size    (in_size),
        .clr_marks  (clr_marks),
        .mark_en    (mark_en),
        .mark_idx   (pick_w[MAX_HOLES]),
        .fit_mode   (fit_mode),
        .hole_count (hole_count),
        .req_size   (req_size),
        .ctl_in     (ctl_w[g]),
        .pick_in    (pick_w[g]),
        .best_in    (best_w[g]),
        .sum_in     (sum_w[g]),
        .ctl_out    (ctl_w[g+1]),
        .pick_out   (pick_w[g+1]),
        .best_out   (best_w[g+1]),
        .sum_out    (sum_w[g+1])
      );
    end
  endgenerate

  // Sequence one request at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (s_tuser == hfa_pkg::CMD_REQ)) begin
            state <= S_SCAN;
            start <= 1'b1;
          end
        end
        S_SCAN: begin
          if (final_step) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the requested size
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == hfa_pkg::CMD_REQ)) begin
      req_size <= in_size;
    end
  end

  // Run totals: drop the granted total on clear, add a granted request
  always_ff @(posedge clk) begin
    if (rst || clr_marks) begin
      granted_total <= '0;
    end else if (mark_en) begin
      granted_total <= granted_total + TOT_W'(req_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hole_total <= '0;
    end else if (final_step) begin
      hole_total <= sum_w[MAX_HOLES];
    end
  end

  // Hold the outcome until the result register is free
  always_ff @(posedge clk) begin
    if (final_step) begin
      res_granted <= final_found;
      res_slot    <= final_found ? pick_w[MAX_HOLES] : '0;
      res_left    <= final_found ? (best_w[MAX_HOLES] - req_size) : '0;
    end
  end

  // Saturate fragmentation at zero and fit fields to port widths
  assign frag      = (hole_total > granted_total) ? (hole_total - granted_total) : '0;
  assign frag_wide = {{hfa_pkg::FRAG_W{1'b0}}, frag};
  assign slot_wide = {{hfa_pkg::SLOT_W{1'b0}}, res_slot};
  assign left_wide = {{hfa_pkg::VALUE_W{1'b0}}, res_left};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'b0,
                  frag_wide[hfa_pkg::FRAG_W-1:0],
                  left_wide[hfa_pkg::VALUE_W-1:0],
                  slot_wide[hfa_pkg::SLOT_W-1:0],
                  res_granted};
    end
  end

endmodule

`default_nettype wire
